/* hdl/dad_pkg.sv */
// Shared constants, types and calendar functions for the date adder.
package dad_pkg;

  localparam int YEAR_BITS   = 16;
  localparam int COUNT_BITS  = 16;
  localparam int DAY_BITS    = 5;
  localparam int MONTH_BITS  = 4;
  localparam int REM_BITS    = 9;

  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;
  localparam int LEAP_PERIOD = 400;
  localparam int CENTURY     = 100;
  localparam int MONTHS      = 12;

  // Width that can hold both the day count and the 400-year day total.
  localparam int WIDE_BITS   = (COUNT_BITS > 18) ? COUNT_BITS : 18;

  localparam logic [MONTH_BITS-1:0] MONTH_JAN = MONTH_BITS'(1);
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(2);
  localparam logic [MONTH_BITS-1:0] MONTH_APR = MONTH_BITS'(4);
  localparam logic [MONTH_BITS-1:0] MONTH_JUN = MONTH_BITS'(6);
  localparam logic [MONTH_BITS-1:0] MONTH_SEP = MONTH_BITS'(9);
  localparam logic [MONTH_BITS-1:0] MONTH_NOV = MONTH_BITS'(11);
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = MONTH_BITS'(MONTHS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM,
    ST_CHECK,
    ST_CYCLE,
    ST_MONTH,
    ST_DONE
  } state_e;

  // Leap test from the year taken modulo 400.
  function automatic logic is_leap(input logic [REM_BITS-1:0] r);
    logic by4;
    by4 = (r[1:0] == 2'b00);
    return by4 && (r != REM_BITS'(CENTURY)) && (r != REM_BITS'(2 * CENTURY))
           && (r != REM_BITS'(3 * CENTURY));
  endfunction

  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                     input logic leap);
    logic [DAY_BITS-1:0] len;
    unique case (m)
      MONTH_FEB: len = leap ? DAY_BITS'(29) : DAY_BITS'(28);
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_BITS'(30);
      default: len = DAY_BITS'(31);
    endcase
    return len;
  endfunction

endpackage

/* hdl/dad_rem400.sv */
// Remainder of a year modulo 400 by reciprocal multiplication; the quotient is registered before the remainder.
module dad_rem400 (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [dad_pkg::YEAR_BITS-1:0]        value_i,
  output logic                                 done_o,
  output logic [dad_pkg::REM_BITS-1:0]         rem_o
);

  localparam int YB    = dad_pkg::YEAR_BITS;
  localparam int RB    = dad_pkg::REM_BITS;
  // The year is 16 * x plus a low nibble, so year / 400 is x / 25. The quotient x / 25
  // comes from a multiply by 2^SHIFT / 25 rounded up, which is exact for x below 2^(YB-4).
  localparam int XB    = YB - 4;
  localparam int KB    = YB - 3;
  localparam int QB    = YB - 8;
  localparam int SHIFT = YB + 1;
  localparam int PB    = XB + KB;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'd24) / 64'd25;

  logic          busy_q;
  logic          quot_ok_q;
  logic [YB-1:0] value_q;
  logic [QB-1:0] quot_q;
  logic [PB-1:0] prod;
  logic [YB-1:0] back;
  logic [YB-1:0] diff;

  always_comb begin
    prod = PB'(value_q[YB-1:4]) * PB'(KB'(RECIP));
    back = YB'(quot_q) * YB'(dad_pkg::LEAP_PERIOD);
    diff = value_q - back;
  end

  // While busy, the quotient is registered first; then done_o presents the remainder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      quot_ok_q <= 1'b0;
    end else if (start_i) begin
      busy_q    <= 1'b1;
      quot_ok_q <= 1'b0;
    end else if (busy_q) begin
      if (quot_ok_q) begin
        busy_q    <= 1'b0;
        quot_ok_q <= 1'b0;
      end else begin
        quot_ok_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      value_q <= value_i;
    end
    if (busy_q && !quot_ok_q) begin
      quot_q <= prod[SHIFT +: QB];
    end
  end

  assign done_o = busy_q && quot_ok_q;
  assign rem_o  = diff[RB-1:0];

endmodule

/* hdl/date_add_days.sv */
// Top level: sequencer that adds a day count to a Gregorian date.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------------
//   input    | in_valid_i/in_ready_o | start_day_i, start_month_i, start_year_i,
//            |                       | days_to_add_i
//   output   | out_valid_o/out_ready_i | end_day_o, end_month_o, end_year_o,
//            |                       | date_invalid_o, year_overflow_o
//
// A valid item runs through the year modulo 400, the date check, one block step per
// 146097-day block and a month step per whole month crossed, then the output load; a
// year wrap in a block step runs the year modulo 400 again. An invalid date skips on to
// the output load. Months are stepped through the single compare-and-subtract unit.
// in_ready_o is high only while the sequencer is idle; a finished result waits in the
// output register and a new item may be taken meanwhile.
// Reset clears the sequencer and the output valid; nothing else needs clearing.
module date_add_days (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dad_pkg::DAY_BITS-1:0]        start_day_i,
  input  logic [dad_pkg::MONTH_BITS-1:0]      start_month_i,
  input  logic [dad_pkg::YEAR_BITS-1:0]       start_year_i,
  input  logic [dad_pkg::COUNT_BITS-1:0]      days_to_add_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dad_pkg::DAY_BITS-1:0]        end_day_o,
  output logic [dad_pkg::MONTH_BITS-1:0]      end_month_o,
  output logic [dad_pkg::YEAR_BITS-1:0]       end_year_o,
  output logic                                date_invalid_o,
  output logic                                year_overflow_o
);

  localparam int YB = dad_pkg::YEAR_BITS;
  localparam int CB = dad_pkg::COUNT_BITS;
  localparam int DB = dad_pkg::DAY_BITS;
  localparam int MB = dad_pkg::MONTH_BITS;
  localparam int RB = dad_pkg::REM_BITS;
  localparam int WB = dad_pkg::WIDE_BITS;

  dad_pkg::state_e state_q, state_d;

  logic [DB-1:0] d_q, d_d;
  logic [MB-1:0] m_q, m_d;
  logic [YB-1:0] y_q, y_d;
  logic [CB-1:0] left_q, left_d;
  logic [RB-1:0] r_q, r_d;
  logic          ovf_q, ovf_d;
  logic          bad_q, bad_d;
  logic          checked_q, checked_d;

  logic          out_valid_q;
  logic [DB-1:0] out_day_q;
  logic [MB-1:0] out_month_q;
  logic [YB-1:0] out_year_q;
  logic          out_bad_q;
  logic          out_ovf_q;
  logic          out_load;

  logic          rem_start;
  logic [YB-1:0] rem_val;
  logic          rem_done;
  logic [RB-1:0] rem_out;

  logic          leap;
  logic [DB-1:0] mlen;
  logic [DB-1:0] rest;
  logic [YB:0]   y_inc;
  logic [YB:0]   y_cyc;
  logic [WB-1:0] left_wide;
  logic [WB-1:0] left_cyc;

  dad_rem400 u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .value_i (rem_val),
    .done_o  (rem_done),
    .rem_o   (rem_out)
  );

  always_comb begin
    leap      = dad_pkg::is_leap(r_q);
    mlen      = dad_pkg::month_len(m_q, leap);
    rest      = mlen - d_q;
    y_inc     = {1'b0, y_q} + (YB + 1)'(1);
    y_cyc     = {1'b0, y_q} + (YB + 1)'(dad_pkg::CYCLE_YEARS);
    left_wide = WB'(left_q);
    left_cyc  = left_wide - WB'(dad_pkg::CYCLE_DAYS);
  end

  always_comb begin
    state_d   = state_q;
    d_d       = d_q;
    m_d       = m_q;
    y_d       = y_q;
    left_d    = left_q;
    r_d       = r_q;
    ovf_d     = ovf_q;
    bad_d     = bad_q;
    checked_d = checked_q;
    rem_start = 1'b0;
    rem_val   = y_q;
    out_load  = 1'b0;

    unique case (state_q)
      dad_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          d_d       = start_day_i;
          m_d       = start_month_i;
          y_d       = start_year_i;
          left_d    = days_to_add_i;
          ovf_d     = 1'b0;
          bad_d     = 1'b0;
          checked_d = 1'b0;
          rem_start = 1'b1;
          rem_val   = start_year_i;
          state_d   = dad_pkg::ST_REM;
        end
      end
      dad_pkg::ST_REM: begin
        if (rem_done) begin
          r_d     = rem_out;
          state_d = checked_q ? dad_pkg::ST_CYCLE : dad_pkg::ST_CHECK;
        end
      end
      dad_pkg::ST_CHECK: begin
        checked_d = 1'b1;
        if ((d_q == '0) || (m_q == '0) || (m_q > dad_pkg::MONTH_DEC) || (d_q > mlen)) begin
          bad_d   = 1'b1;
          state_d = dad_pkg::ST_DONE;
        end else begin
          state_d = dad_pkg::ST_CYCLE;
        end
      end
      dad_pkg::ST_CYCLE: begin
        // Whole 400-year blocks keep the leap phase unless the year wraps.
        if (left_wide >= WB'(dad_pkg::CYCLE_DAYS)) begin
          left_d = left_cyc[CB-1:0];
          y_d    = y_cyc[YB-1:0];
          if (y_cyc[YB]) begin
            ovf_d     = 1'b1;
            rem_start = 1'b1;
            rem_val   = y_cyc[YB-1:0];
            state_d   = dad_pkg::ST_REM;
          end
        end else begin
          state_d = dad_pkg::ST_MONTH;
        end
      end
      dad_pkg::ST_MONTH: begin
        if (left_q == '0) begin
          state_d = dad_pkg::ST_DONE;
        end else if (left_q > CB'(rest)) begin
          left_d = left_q - CB'(rest) - CB'(1);
          d_d    = DB'(1);
          if (m_q == dad_pkg::MONTH_DEC) begin
            m_d = dad_pkg::MONTH_JAN;
            y_d = y_inc[YB-1:0];
            if (y_inc[YB]) begin
              ovf_d = 1'b1;
              r_d   = '0;
            end else if (r_q == RB'(dad_pkg::LEAP_PERIOD - 1)) begin
              r_d = '0;
            end else begin
              r_d = r_q + RB'(1);
            end
          end else begin
            m_d = m_q + MB'(1);
          end
        end else begin
          d_d     = d_q + left_q[DB-1:0];
          left_d  = '0;
          state_d = dad_pkg::ST_DONE;
        end
      end
      dad_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = dad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dad_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dad_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q       <= d_d;
    m_q       <= m_d;
    y_q       <= y_d;
    left_q    <= left_d;
    r_q       <= r_d;
    ovf_q     <= ovf_d;
    bad_q     <= bad_d;
    checked_q <= checked_d;
    if (out_load) begin
      out_day_q   <= d_q;
      out_month_q <= m_q;
      out_year_q  <= y_q;
      out_bad_q   <= bad_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign in_ready_o      = (state_q == dad_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign end_day_o       = out_day_q;
  assign end_month_o     = out_month_q;
  assign end_year_o      = out_year_q;
  assign date_invalid_o  = out_bad_q;
  assign year_overflow_o = out_ovf_q;

  // A valid result always has a nonzero day and a month from 1 to 12.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !date_invalid_o) |->
      (end_day_o != '0) && (end_month_o != '0) && (end_month_o <= dad_pkg::MONTH_DEC))
    else $error("result date out of range");

  // A rejected start date never reports a year overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && date_invalid_o) |-> !year_overflow_o)
    else $error("overflow flagged on an invalid date");

  // The remainder unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == dad_pkg::ST_REM))
    else $error("remainder finished outside its wait state");

  // The year phase stays below 400 while months are stepped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dad_pkg::ST_MONTH) |-> (r_q < RB'(dad_pkg::LEAP_PERIOD)))
    else $error("year phase out of range");

  // The day never passes the length of its month while stepping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dad_pkg::ST_MONTH) |-> (d_q <= mlen) && (d_q != '0))
    else $error("working day outside its month");

endmodule
